// File: rtl/fcmab_pkg.sv
// ----------------------------------------------------------------------------
// fcmab_pkg: shared definitions for the four-channel moving average
// Field widths, request codes, channel indices and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package fcmab_pkg;

  // default window depth, entries per channel
  localparam int unsigned WINDOW_DEPTH_DEF = 16;

  // field widths
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned AVG_W       = 17;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned NUM_CH      = 4;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 72;

  // request codes carried in in_tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_MEASURE    = 2'd0,
    FUNC_CAL_BEGIN  = 2'd1,
    FUNC_CAL_SAMPLE = 2'd2
  } func_t;

  // channel order, also the packing order in tdata
  typedef enum logic [1:0] {
    CH_CELL      = 2'd0,
    CH_BUS       = 2'd1,
    CH_BATTERY   = 2'd2,
    CH_CONVERTER = 2'd3
  } chan_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// File: rtl/fcmab_ram.sv
// ----------------------------------------------------------------------------
// fcmab_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fcmab_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/fcmab_div.sv
// ----------------------------------------------------------------------------
// fcmab_div: bit-serial signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fcmab_div #(
  parameter int unsigned SUM_W = 20,
  parameter int unsigned CNT_W = 5
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [SUM_W-1:0]             dividend,
  input  wire logic        [CNT_W-1:0]             divisor,
  output logic                                     done,
  output logic             [fcmab_pkg::SAMPLE_W-1:0] quotient
);

  localparam int unsigned CW = $clog2(SUM_W);

  logic                           busy_r;
  logic                           done_r;
  logic                           neg_r;
  logic [CW-1:0]                  cnt_r;
  logic [SUM_W-1:0]               quo_r;
  logic [CNT_W-1:0]               rem_r;
  logic [fcmab_pkg::SAMPLE_W-1:0] res_r;

  logic [SUM_W-1:0]               mag;
  logic [CNT_W:0]                 trial;
  logic [CNT_W:0]                 diff;
  logic                           fits;
  logic [CNT_W-1:0]               rem_nxt;
  logic [SUM_W-1:0]               quo_nxt;
  logic                           last;

  // magnitude of the dividend
  assign mag = dividend[SUM_W-1] ? (~$unsigned(dividend) + 1'b1) : $unsigned(dividend);

  // one restoring step: shift in the next dividend bit, try the subtract
  assign trial   = {rem_r, quo_r[SUM_W-1]};
  assign diff    = trial - {1'b0, divisor};
  assign fits    = (trial >= {1'b0, divisor});
  assign rem_nxt = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  assign quo_nxt = {quo_r[SUM_W-2:0], fits};
  assign last    = (cnt_r == CW'(SUM_W - 1));

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // shift registers and result
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      quo_r <= mag;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      if (last) begin
        res_r <= neg_r ? (~quo_nxt[fcmab_pkg::SAMPLE_W-1:0] + 1'b1)
                       : quo_nxt[fcmab_pkg::SAMPLE_W-1:0];
      end
    end
  end

  assign done     = done_r;
  assign quotient = res_r;

endmodule

`default_nettype wire

// File: rtl/four_channel_moving_average_bias.sv
// ----------------------------------------------------------------------------
// four_channel_moving_average_bias: windowed averages with current bias
// Measure request: a sequential window read, then the shared bit-serial divider
//   on each of the four channels in turn, then the result goes to the output
//   register, which waits while the output side holds the previous result back.
// Calibration sample that wraps the window: read, then divide the two current channels.
// Other requests finish without leaving idle. One request in flight at a time.
// Reset (synchronous, active low) clears position, full flag, bus valid bits,
// offsets and handshake state; window memories need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_moving_average_bias #(
  parameter int unsigned WINDOW_DEPTH = fcmab_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // in_tdata: cell_sample, bus_sample, battery_current_sample,
  //           converter_current_sample (16 bits each, lowest first)
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [fcmab_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: func
  input  wire logic [fcmab_pkg::FUNC_W-1:0]         in_tuser,
  // out_tdata: cell_average (16), bus_average (16),
  //            battery_current_average (17), converter_current_average (17),
  //            zero padding
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic      [fcmab_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int unsigned SW    = fcmab_pkg::SAMPLE_W;
  localparam int unsigned AW    = fcmab_pkg::AVG_W;
  localparam int unsigned NCH   = fcmab_pkg::NUM_CH;
  localparam int unsigned POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W = SW + $clog2(WINDOW_DEPTH);
  localparam int unsigned PAD_W = fcmab_pkg::OUT_TDATA_W - 2 * SW - 2 * AW;

  fcmab_pkg::state_t state_r, state_nxt;
  fcmab_pkg::chan_t  ch_r;

  logic [POS_W-1:0]         pos_r;
  logic                     full_r;
  logic [WINDOW_DEPTH-1:0]  bus_valid_r;
  logic [CNT_W-1:0]         count_r;
  logic                     cal_r;
  logic [CNT_W-1:0]         rd_cnt_r;
  logic                     rd_vld_r;
  logic                     bus_ok_r;
  logic signed [SUM_W-1:0]  acc_r [NCH];
  logic [SW-1:0]            mean_r [NCH];
  logic [SW-1:0]            bat_off_r;
  logic [SW-1:0]            conv_off_r;
  logic                     out_tvalid_r;
  logic [fcmab_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic                     accept;
  logic [CNT_W-1:0]         pos_inc;
  logic                     pos_wrap;
  logic [POS_W-1:0]         pos_adv;
  logic [POS_W-1:0]         rd_addr;
  logic                     rd_en;
  logic                     wr_main;
  logic                     wr_bus;
  logic                     div_start;
  logic                     div_done;
  logic [SW-1:0]            div_q;
  logic                     out_load;
  logic [NCH-1:0]           wr_en;
  logic [SW-1:0]            rd_data [NCH];
  logic signed [SUM_W-1:0]  rd_term [NCH];
  logic [AW-1:0]            bat_avg;
  logic [AW-1:0]            conv_avg;

  assign accept  = in_tvalid && in_tready;
  assign rd_addr = rd_cnt_r[POS_W-1:0];

  // write position advance with wrap
  assign pos_inc  = CNT_W'(pos_r) + 1'b1;
  assign pos_wrap = (pos_inc == CNT_W'(WINDOW_DEPTH));
  assign pos_adv  = pos_wrap ? '0 : pos_inc[POS_W-1:0];

  // window memories, one per channel, sharing the write position
  for (genvar g = 0; g < NCH; g++) begin : g_win
    assign wr_en[g] = (g == int'(fcmab_pkg::CH_BUS)) ? wr_bus : wr_main;

    fcmab_ram #(
      .WIDTH (SW),
      .DEPTH (WINDOW_DEPTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en[g]),
      .wr_addr (pos_r),
      .wr_data (in_tdata[g*SW +: SW]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data[g])
    );

    // bus entries never written since reset read as zero
    if (g == int'(fcmab_pkg::CH_BUS)) begin : g_mask
      assign rd_term[g] = bus_ok_r ? SUM_W'($signed(rd_data[g])) : '0;
    end else begin : g_plain
      assign rd_term[g] = SUM_W'($signed(rd_data[g]));
    end
  end

  // shared serial divider
  fcmab_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r[ch_r]),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcmab_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    rd_en     = 1'b0;
    wr_main   = 1'b0;
    wr_bus    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      fcmab_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_tuser)
            fcmab_pkg::FUNC_MEASURE: begin
              wr_main   = 1'b1;
              wr_bus    = 1'b1;
              state_nxt = fcmab_pkg::ST_SUM;
            end
            fcmab_pkg::FUNC_CAL_SAMPLE: begin
              wr_main = 1'b1;
              if (pos_wrap) begin
                state_nxt = fcmab_pkg::ST_SUM;
              end
            end
            default: ;
          endcase
        end
      end
      fcmab_pkg::ST_SUM: begin
        rd_en = (rd_cnt_r != count_r);
        if (!rd_en && !rd_vld_r) begin
          state_nxt = fcmab_pkg::ST_DIV_START;
        end
      end
      fcmab_pkg::ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = fcmab_pkg::ST_DIV_WAIT;
      end
      fcmab_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          if (ch_r == fcmab_pkg::CH_CONVERTER) begin
            state_nxt = cal_r ? fcmab_pkg::ST_IDLE : fcmab_pkg::ST_OUT;
          end else begin
            state_nxt = fcmab_pkg::ST_DIV_START;
          end
        end
      end
      fcmab_pkg::ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = fcmab_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fcmab_pkg::ST_IDLE;
    endcase
  end

  // window control, offsets and channel sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      full_r      <= 1'b0;
      bus_valid_r <= '0;
      cal_r       <= 1'b0;
      ch_r        <= fcmab_pkg::CH_CELL;
      rd_cnt_r    <= '0;
      rd_vld_r    <= 1'b0;
      bat_off_r   <= '0;
      conv_off_r  <= '0;
    end else begin
      if (accept) begin
        rd_cnt_r <= '0;
        rd_vld_r <= 1'b0;
        unique case (in_tuser)
          fcmab_pkg::FUNC_MEASURE: begin
            bus_valid_r[pos_r] <= 1'b1;
            count_r <= full_r ? CNT_W'(WINDOW_DEPTH) : pos_inc;
            pos_r   <= pos_adv;
            if (pos_wrap) begin
              full_r <= 1'b1;
            end
            cal_r <= 1'b0;
            ch_r  <= fcmab_pkg::CH_CELL;
          end
          fcmab_pkg::FUNC_CAL_BEGIN: begin
            pos_r  <= '0;
            full_r <= 1'b0;
          end
          fcmab_pkg::FUNC_CAL_SAMPLE: begin
            count_r <= CNT_W'(WINDOW_DEPTH);
            pos_r   <= pos_adv;
            if (pos_wrap) begin
              full_r <= 1'b1;
            end
            cal_r <= 1'b1;
            ch_r  <= fcmab_pkg::CH_BATTERY;
          end
          default: ;
        endcase
      end else if (state_r == fcmab_pkg::ST_SUM) begin
        rd_vld_r <= rd_en;
        if (rd_en) begin
          rd_cnt_r <= rd_cnt_r + 1'b1;
        end
      end else if (state_r == fcmab_pkg::ST_DIV_WAIT && div_done) begin
        // offsets latch on a calibration wrap
        if (cal_r && ch_r == fcmab_pkg::CH_BATTERY) begin
          bat_off_r <= div_q;
        end
        if (cal_r && ch_r == fcmab_pkg::CH_CONVERTER) begin
          conv_off_r <= div_q;
        end
        if (ch_r != fcmab_pkg::CH_CONVERTER) begin
          ch_r <= fcmab_pkg::chan_t'(ch_r + 1'b1);
        end
      end
    end
  end

  // window accumulation, one entry per cycle
  always_ff @(posedge clk) begin
    if (state_r == fcmab_pkg::ST_SUM && rd_en) begin
      bus_ok_r <= bus_valid_r[rd_addr];
    end
    for (int i = 0; i < NCH; i++) begin
      if (accept) begin
        acc_r[i] <= '0;
      end else if (rd_vld_r) begin
        acc_r[i] <= acc_r[i] + rd_term[i];
      end
    end
    if (state_r == fcmab_pkg::ST_DIV_WAIT && div_done) begin
      mean_r[ch_r] <= div_q;
    end
  end

  // bias removal on the two current channels
  assign bat_avg  = {mean_r[fcmab_pkg::CH_BATTERY][SW-1], mean_r[fcmab_pkg::CH_BATTERY]}
                  - {bat_off_r[SW-1], bat_off_r};
  assign conv_avg = {mean_r[fcmab_pkg::CH_CONVERTER][SW-1], mean_r[fcmab_pkg::CH_CONVERTER]}
                  - {conv_off_r[SW-1], conv_off_r};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {{PAD_W{1'b0}}, conv_avg, bat_avg,
                     mean_r[fcmab_pkg::CH_BUS], mean_r[fcmab_pkg::CH_CELL]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/fcmab_checker.sv
// ----------------------------------------------------------------------------
// fcmab_checker: port-level checks for the moving average block
// Handshake and sequencing properties, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fcmab_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [fcmab_pkg::FUNC_W-1:0]      in_tuser,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [fcmab_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a measure request keeps the input side busy while it is worked on
  a_measure_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == fcmab_pkg::FUNC_MEASURE |=> !in_tready)
    else $error("input taken during a measure request");

  // no result appears in the cycle after any request
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result too early");

  // a new result is only loaded while the input side is busy
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result loaded while idle");

endmodule

bind four_channel_moving_average_bias fcmab_checker u_fcmab_checker (.*);

`default_nettype wire
